/* design/dpsu_pkg.sv */
// Package for the dual pulse sound unit: action codes, register offsets, tables and channel state.
package dpsu_pkg;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CYCLE = 2'd2,
    ACT_FRAME = 2'd3
  } action_t;

  // Register offsets within a pulse channel
  localparam logic [1:0] PREG_CTRL   = 2'd0;
  localparam logic [1:0] PREG_LOW    = 2'd2;
  localparam logic [1:0] PREG_HIGH   = 2'd3;

  // Bus offsets outside the pulse channels
  localparam logic [4:0] OFF_PCM_CTRL = 5'd16;
  localparam logic [4:0] OFF_PCM_RAW  = 5'd17;
  localparam logic [4:0] OFF_ENABLE   = 5'd21;

  localparam int NumChan = 2;

  typedef struct packed {
    logic [10:0] period;
    logic [1:0]  duty_select;
    logic [2:0]  sequence_step;
    logic [12:0] timer_count;
    logic [3:0]  env_speed;
    logic        env_constant;
    logic        loop_halt;
    logic        env_restart;
    logic [4:0]  env_divider;
    logic [3:0]  decay_level;
    logic [7:0]  length_count;
    logic        length_enable;
  } chan_t;

  function automatic logic duty_bit(input logic [1:0] sel, input logic [2:0] step);
    logic [7:0] row;
    begin
      unique case (sel)
        2'd0: row = 8'b0000_0010;
        2'd1: row = 8'b0000_0110;
        2'd2: row = 8'b0001_1110;
        default: row = 8'b1111_1001;
      endcase
      duty_bit = row[step];
    end
  endfunction

  function automatic logic [7:0] length_load(input logic [4:0] idx);
    logic [7:0] val;
    begin
      unique case (idx)
        5'd0:  val = 8'd10;  5'd1:  val = 8'd254; 5'd2:  val = 8'd20;  5'd3:  val = 8'd2;
        5'd4:  val = 8'd40;  5'd5:  val = 8'd4;   5'd6:  val = 8'd80;  5'd7:  val = 8'd6;
        5'd8:  val = 8'd160; 5'd9:  val = 8'd8;   5'd10: val = 8'd60;  5'd11: val = 8'd10;
        5'd12: val = 8'd14;  5'd13: val = 8'd12;  5'd14: val = 8'd26;  5'd15: val = 8'd14;
        5'd16: val = 8'd12;  5'd17: val = 8'd16;  5'd18: val = 8'd24;  5'd19: val = 8'd18;
        5'd20: val = 8'd48;  5'd21: val = 8'd20;  5'd22: val = 8'd96;  5'd23: val = 8'd22;
        5'd24: val = 8'd192; 5'd25: val = 8'd24;  5'd26: val = 8'd72;  5'd27: val = 8'd26;
        5'd28: val = 8'd16;  5'd29: val = 8'd28;  5'd30: val = 8'd32;  default: val = 8'd30;
      endcase
      length_load = val;
    end
  endfunction

  function automatic logic [3:0] pulse_level(input chan_t c);
    logic [3:0] vol;
    begin
      vol = c.env_constant ? c.env_speed : c.decay_level;
      if (c.length_count == 8'd0 || !duty_bit(c.duty_select, c.sequence_step)) begin
        pulse_level = 4'd0;
      end else begin
        pulse_level = vol;
      end
    end
  endfunction

endpackage

/* design/dpsu_if.sv */
// Valid/ready channel interfaces for the dual pulse sound unit.
interface dpsu_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [4:0] register_offset;
  logic [7:0] write_data;

  modport source (output valid, action, register_offset, write_data, input ready);
  modport sink (input valid, action, register_offset, write_data, output ready);
endinterface

interface dpsu_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] read_data;
  logic [3:0] pulse_one_level;
  logic [3:0] pulse_two_level;
  logic [7:0] pcm_level;

  modport source (output valid, read_data, pulse_one_level, pulse_two_level, pcm_level,
                  input ready);
  modport sink (input valid, read_data, pulse_one_level, pulse_two_level, pcm_level,
                output ready);
endinterface

/* design/dual_pulse_sound_unit.sv */
// Top level of the dual pulse sound unit: two pulse channels, a raw PCM register and a PCM control register.
//
// Usage: every beat on req carries one action (register write, status read, CPU cycle
// tick or frame tick) with its offset and data byte. Every accepted beat produces
// exactly one beat on rsp: the status bits, both pulse levels and the PCM level,
// all taken from the state after the action is applied.
// The state registers and the result register load at the edge that accepts the
// beat, and rsp.valid is high from the next cycle on.
// The block takes one beat per cycle while rsp is not stalled; the next-state logic is
// a single pass of a 13-bit add per channel plus table lookups, so nothing iterates.
// When rsp is stalled the result register holds its beat and req.ready drops;
// req.ready is high whenever the result register is empty or being drained, so
// a new beat is taken in the same cycle that the old result leaves.
// Reset (rst, synchronous) clears all channel state, the PCM registers and
// rsp.valid; the block is ready in the first cycle after reset.
module dual_pulse_sound_unit
  import dpsu_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  dpsu_in_if.sink        req,
  dpsu_out_if.source     rsp
);

  chan_t      chan [NumChan];
  chan_t      chan_next [NumChan];
  logic [7:0] pcm_control;
  logic [7:0] pcm_control_next;
  logic [7:0] pcm_raw;
  logic [7:0] pcm_raw_next;
  logic       accept;
  action_t    act;

  assign req.ready = !rst && (!rsp.valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign act       = action_t'(req.action);

  always_comb begin
    logic        hit;
    logic [11:0] p1;
    logic [12:0] wl;
    logic [13:0] sum;
    logic [4:0]  div;
    pcm_control_next = pcm_control;
    pcm_raw_next     = pcm_raw;
    if (act == ACT_WRITE && req.register_offset == OFF_PCM_CTRL) begin
      pcm_control_next = req.write_data;
    end
    if (act == ACT_WRITE && req.register_offset == OFF_PCM_RAW) begin
      pcm_raw_next = req.write_data;
    end
    for (int c = 0; c < NumChan; c++) begin
      chan_next[c] = chan[c];
      hit = (req.register_offset[4:3] == 2'd0) && (req.register_offset[2] == 1'(c));
      p1  = {1'b0, chan[c].period} + 12'd1;
      wl  = {p1, 1'b0};
      sum = {1'b0, chan[c].timer_count} + {1'b0, wl} - 14'd1;
      div = 5'd0;
      unique case (act)
        ACT_WRITE: begin
          if (hit && req.register_offset[1:0] == PREG_CTRL) begin
            chan_next[c].env_speed    = req.write_data[3:0];
            chan_next[c].env_constant = req.write_data[4];
            chan_next[c].loop_halt    = req.write_data[5];
            chan_next[c].duty_select  = req.write_data[7:6];
          end
          if (hit && req.register_offset[1:0] == PREG_LOW) begin
            chan_next[c].period[7:0] = req.write_data;
          end
          if (hit && req.register_offset[1:0] == PREG_HIGH) begin
            chan_next[c].period[10:8]  = req.write_data[2:0];
            chan_next[c].sequence_step = 3'd0;
            chan_next[c].env_restart   = 1'b1;
            if (chan[c].length_enable) begin
              chan_next[c].length_count = length_load(req.write_data[7:3]);
            end
          end
          if (req.register_offset == OFF_ENABLE) begin
            chan_next[c].length_enable = req.write_data[c];
            if (!req.write_data[c]) begin
              chan_next[c].length_count = 8'd0;
            end
          end
        end
        ACT_CYCLE: begin
          if (chan[c].timer_count <= 13'd1) begin
            // expire: reload with the leftover count plus 2*(period+1) minus 1 and step the sequencer backwards
            chan_next[c].timer_count   = sum[12:0];
            chan_next[c].sequence_step = chan[c].sequence_step - 3'd1;
          end else begin
            chan_next[c].timer_count = chan[c].timer_count - 13'd1;
          end
        end
        ACT_FRAME: begin
          if (!chan[c].loop_halt && chan[c].length_count != 8'd0) begin
            chan_next[c].length_count = chan[c].length_count - 8'd1;
          end
          if (chan[c].env_restart) begin
            chan_next[c].env_divider = {1'b0, chan[c].env_speed} + 5'd1;
            chan_next[c].decay_level = 4'hF;
            chan_next[c].env_restart = 1'b0;
          end else begin
            div = (chan[c].env_divider != 5'd0) ? chan[c].env_divider - 5'd1 : 5'd0;
            if (div == 5'd0) begin
              chan_next[c].env_divider = {1'b0, chan[c].env_speed} + 5'd1;
              if (chan[c].loop_halt || chan[c].decay_level != 4'd0) begin
                chan_next[c].decay_level = chan[c].decay_level - 4'd1;
              end
            end else begin
              chan_next[c].env_divider = div;
            end
          end
        end
        default: begin
          // status read: no side effect
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NumChan; c++) begin
        chan[c] <= '0;
      end
      pcm_control <= 8'd0;
      pcm_raw     <= 8'd0;
    end else if (accept) begin
      for (int c = 0; c < NumChan; c++) begin
        chan[c] <= chan_next[c];
      end
      pcm_control <= pcm_control_next;
      pcm_raw     <= pcm_raw_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (accept) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  // result payload is taken from the post-action state
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.read_data       <= {chan_next[1].length_count != 8'd0,
                              chan_next[0].length_count != 8'd0};
      rsp.pulse_one_level <= pulse_level(chan_next[0]);
      rsp.pulse_two_level <= pulse_level(chan_next[1]);
      rsp.pcm_level       <= pcm_control_next[6] ? 8'd0 : pcm_raw_next;
    end
  end

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> rsp.valid)
    else $error("accepted beat produced no result");

  a_len_needs_enable: assert property (@(posedge clk) disable iff (rst)
    (chan[0].length_count != 8'd0) |-> chan[0].length_enable)
    else $error("pulse one length count live while disabled");

  a_env_divider_range: assert property (@(posedge clk) disable iff (rst)
    (chan[1].env_divider <= 5'd16))
    else $error("pulse two envelope divider out of range");

  a_restart_loads_decay: assert property (@(posedge clk) disable iff (rst)
    (accept && act == ACT_FRAME && chan[0].env_restart)
      |=> (chan[0].decay_level == 4'hF && !chan[0].env_restart))
    else $error("envelope restart did not reload pulse one");

  a_status_matches_len: assert property (@(posedge clk) disable iff (rst)
    accept |=> (rsp.read_data[1] == (chan[1].length_count != 8'd0)))
    else $error("status bit disagrees with pulse two length count");

endmodule
